FILE: design/bcf_pkg.sv
// shared constants, payload types and helpers of the bezier curve flattener
package bcf_pkg;

    localparam int MAX_DEPTH   = 4;
    localparam int STACK_SLOTS = MAX_DEPTH + 2;
    localparam int LEVEL_W     = $clog2(MAX_DEPTH + 2);
    localparam int SP_W        = $clog2(STACK_SLOTS + 1);
    localparam int ADDR_W      = $clog2(STACK_SLOTS);

    localparam int COORD_W = 24;
    localparam int STEP_W  = 16;
    localparam int DIFF_W  = COORD_W + 3;
    localparam int ABS_W   = COORD_W + 2;
    localparam int SUM_W   = ABS_W + 2;
    localparam int SQ_W    = 2 * COORD_W;

    localparam logic [STEP_W-1:0]   STEP_RESET    = 16'd256;
    localparam logic [2*STEP_W-1:0] STEP_SQ_RESET = 32'd65536;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [LEVEL_W-1:0]        level_t;

    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t ctrl1_x;
        coord_t ctrl1_y;
        coord_t ctrl2_x;
        coord_t ctrl2_y;
        coord_t end_x;
        coord_t end_y;
        logic   path_start;
    } bcf_in_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        logic   run_last;
    } bcf_out_t;

    // one pending right half on the stack
    typedef struct packed {
        coord_t x0;
        coord_t y0;
        coord_t x1;
        coord_t y1;
        coord_t x2;
        coord_t y2;
        coord_t x3;
        coord_t y3;
        level_t level;
    } bcf_entry_t;

    localparam int ENTRY_W = $bits(bcf_entry_t);

    // floor((a + b) / 2), exact on the sum
    function automatic coord_t mid2(coord_t a, coord_t b);
        logic signed [COORD_W:0] s;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        return s[COORD_W:1];
    endfunction

endpackage

FILE: design/bcf_ifs.sv
// valid/ready channel interfaces for segments in and polyline points out
interface bcf_seg_if;
    import bcf_pkg::*;
    logic    valid;
    logic    ready;
    bcf_in_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bcf_pt_if;
    import bcf_pkg::*;
    logic     valid;
    logic     ready;
    bcf_out_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: design/bcf_ram.sv
// generic single write port ram with registered read
module bcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: design/bezier_curve_flattener_unit.sv
// cubic bezier flattener: adaptive midpoint subdivision with a stack in ram
//
// seg takes one cubic segment (four control points, signed Q15.8, and a
// path_start flag) when valid and ready are both high; ready is high only
// while the unit is idle, so one segment is worked on at a time. pts gives
// the polyline points; run_last marks the segment end point, which closes
// every run. cfg_we writes min_step (unsigned Q8.8); the user must write
// it only while the unit is idle, which the block does not enforce. For
// one segment the unit accepts it, emits the start point if asked, walks
// the splits and leaves, emitting a leaf midpoint when it lies farther
// than min_step from the last point, pops pending halves from the stack
// ram and emits the end point. A fully split segment has 2^(MAX_DEPTH+1)
// leaves. Each point waits in an output register; the walk stalls
// only when a new point is due while that register is still full, so a
// stalled receiver holds the unit without loss. After the end point is
// loaded the next segment is accepted at once. Reset clears the last
// point to 0,0 and min_step to 1.0; the stack ram needs no clearing.
module bezier_curve_flattener_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    bcf_seg_if.sink                     seg,
    bcf_pt_if.source                    pts,
    input  logic                        cfg_we,
    input  logic [bcf_pkg::STEP_W-1:0]  cfg_wdata
);

    import bcf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_EVAL1,
        S_EVAL2,
        S_EVAL3,
        S_DECIDE,
        S_DIST1,
        S_DIST2,
        S_DIST3,
        S_CMP,
        S_EMIT_MID,
        S_POP,
        S_LOAD,
        S_EMIT_END
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [SP_W-1:0]     sp_reg;
    level_t              level_reg;
    coord_t              last_x_reg;
    coord_t              last_y_reg;
    logic [STEP_W-1:0]   min_step_reg;
    logic [2*STEP_W-1:0] step_sq_reg;
    logic                out_valid_reg;
    bcf_out_t            out_data_reg;

    coord_t cur_reg [8];
    coord_t end_x_reg;
    coord_t end_y_reg;
    coord_t p_x_reg, p_y_reg, q_x_reg, q_y_reg, r_x_reg, r_y_reg;
    coord_t k_x_reg, k_y_reg, l_x_reg, l_y_reg, m_x_reg, m_y_reg;
    logic signed [DIFF_W-1:0] d1x_reg, d1y_reg, d2x_reg, d2y_reg;
    logic [ABS_W-1:0]   a1x_reg, a1y_reg, a2x_reg, a2y_reg;
    logic [SUM_W-1:0]   s_reg;
    logic [COORD_W-1:0] adx_reg, ady_reg;
    logic [SQ_W-1:0]    sqx_reg, sqy_reg;

    logic       out_free;
    logic       out_load;
    logic       leaf;
    logic       far;
    logic       ram_we;
    logic       ram_re;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    bcf_entry_t ram_wentry;
    logic [ENTRY_W-1:0] ram_rdata;
    bcf_entry_t pop_entry;

    logic signed [DIFF_W-1:0] e0x, e0y, e1x, e1y, e2x, e2y, e3x, e3y;
    logic signed [COORD_W:0]  dx, dy;
    logic [SQ_W:0]            dist_sq;

    assign seg.ready = (state_reg == S_IDLE);
    assign pts.valid = out_valid_reg;
    assign pts.data  = out_data_reg;
    assign out_free  = !out_valid_reg || pts.ready;
    assign out_load  = out_free && (state_reg inside {S_START, S_EMIT_MID, S_EMIT_END});

    assign leaf = ({s_reg, 2'b00} < (SUM_W + 2)'(min_step_reg))
               || (level_reg > LEVEL_W'(MAX_DEPTH));
    assign dist_sq = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign far     = dist_sq > (SQ_W + 1)'(step_sq_reg);

    assign e0x = DIFF_W'(cur_reg[0]);
    assign e0y = DIFF_W'(cur_reg[1]);
    assign e1x = DIFF_W'(cur_reg[2]);
    assign e1y = DIFF_W'(cur_reg[3]);
    assign e2x = DIFF_W'(cur_reg[4]);
    assign e2y = DIFF_W'(cur_reg[5]);
    assign e3x = DIFF_W'(cur_reg[6]);
    assign e3y = DIFF_W'(cur_reg[7]);

    assign dx = {m_x_reg[COORD_W-1], m_x_reg} - {last_x_reg[COORD_W-1], last_x_reg};
    assign dy = {m_y_reg[COORD_W-1], m_y_reg} - {last_y_reg[COORD_W-1], last_y_reg};

    // push the right half while the left half is walked next
    assign ram_we    = (state_reg == S_DECIDE) && !leaf && (sp_reg < SP_W'(STACK_SLOTS));
    assign ram_waddr = sp_reg[ADDR_W-1:0];
    assign ram_re    = (state_reg == S_POP);
    assign ram_raddr = ADDR_W'(sp_reg - SP_W'(1));
    assign pop_entry = bcf_entry_t'(ram_rdata);

    always_comb
    begin
        ram_wentry.x0    = m_x_reg;
        ram_wentry.y0    = m_y_reg;
        ram_wentry.x1    = l_x_reg;
        ram_wentry.y1    = l_y_reg;
        ram_wentry.x2    = r_x_reg;
        ram_wentry.y2    = r_y_reg;
        ram_wentry.x3    = cur_reg[6];
        ram_wentry.y3    = cur_reg[7];
        ram_wentry.level = level_reg + LEVEL_W'(1);
    end

    bcf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STACK_SLOTS)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (seg.valid)
                begin
                    state_next = seg.data.path_start ? S_START : S_EVAL1;
                end
            end
            S_START:
            begin
                if (out_free)
                begin
                    state_next = S_EVAL1;
                end
            end
            S_EVAL1:  state_next = S_EVAL2;
            S_EVAL2:  state_next = S_EVAL3;
            S_EVAL3:  state_next = S_DECIDE;
            S_DECIDE: state_next = leaf ? S_DIST1 : S_EVAL1;
            S_DIST1:  state_next = S_DIST2;
            S_DIST2:  state_next = S_DIST3;
            S_DIST3:  state_next = S_CMP;
            S_CMP:
            begin
                if (far)
                begin
                    state_next = S_EMIT_MID;
                end
                else
                begin
                    state_next = (sp_reg == '0) ? S_EMIT_END : S_POP;
                end
            end
            S_EMIT_MID:
            begin
                if (out_free)
                begin
                    state_next = (sp_reg == '0) ? S_EMIT_END : S_POP;
                end
            end
            S_POP:    state_next = S_LOAD;
            S_LOAD:   state_next = S_EVAL1;
            S_EMIT_END:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // control state, stack pointer, level, last point, min_step and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            level_reg     <= '0;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            min_step_reg  <= STEP_RESET;
            step_sq_reg   <= STEP_SQ_RESET;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                min_step_reg <= cfg_wdata;
                step_sq_reg  <= cfg_wdata * cfg_wdata;
            end
            out_valid_reg <= out_load || (out_valid_reg && !pts.ready);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (seg.valid)
                    begin
                        sp_reg    <= '0;
                        level_reg <= '0;
                    end
                end
                S_START:
                begin
                    if (out_free)
                    begin
                        out_data_reg.point_x  <= cur_reg[0];
                        out_data_reg.point_y  <= cur_reg[1];
                        out_data_reg.run_last <= 1'b0;
                        last_x_reg            <= cur_reg[0];
                        last_y_reg            <= cur_reg[1];
                    end
                end
                S_DECIDE:
                begin
                    if (!leaf)
                    begin
                        level_reg <= level_reg + LEVEL_W'(1);
                        if (ram_we)
                        begin
                            sp_reg <= sp_reg + SP_W'(1);
                        end
                    end
                end
                S_EMIT_MID:
                begin
                    if (out_free)
                    begin
                        out_data_reg.point_x  <= m_x_reg;
                        out_data_reg.point_y  <= m_y_reg;
                        out_data_reg.run_last <= 1'b0;
                        last_x_reg            <= m_x_reg;
                        last_y_reg            <= m_y_reg;
                    end
                end
                S_POP:
                begin
                    sp_reg <= sp_reg - SP_W'(1);
                end
                S_LOAD:
                begin
                    level_reg <= pop_entry.level;
                end
                S_EMIT_END:
                begin
                    if (out_free)
                    begin
                        out_data_reg.point_x  <= end_x_reg;
                        out_data_reg.point_y  <= end_y_reg;
                        out_data_reg.run_last <= 1'b1;
                        last_x_reg            <= end_x_reg;
                        last_y_reg            <= end_y_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // subdivision datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (seg.valid)
                begin
                    cur_reg[0] <= seg.data.start_x;
                    cur_reg[1] <= seg.data.start_y;
                    cur_reg[2] <= seg.data.ctrl1_x;
                    cur_reg[3] <= seg.data.ctrl1_y;
                    cur_reg[4] <= seg.data.ctrl2_x;
                    cur_reg[5] <= seg.data.ctrl2_y;
                    cur_reg[6] <= seg.data.end_x;
                    cur_reg[7] <= seg.data.end_y;
                    end_x_reg  <= seg.data.end_x;
                    end_y_reg  <= seg.data.end_y;
                end
            end
            S_EVAL1:
            begin
                p_x_reg <= mid2(cur_reg[0], cur_reg[2]);
                p_y_reg <= mid2(cur_reg[1], cur_reg[3]);
                q_x_reg <= mid2(cur_reg[2], cur_reg[4]);
                q_y_reg <= mid2(cur_reg[3], cur_reg[5]);
                r_x_reg <= mid2(cur_reg[4], cur_reg[6]);
                r_y_reg <= mid2(cur_reg[5], cur_reg[7]);
                // second differences of the control polygon
                d1x_reg <= e0x + e2x - (e1x <<< 1);
                d1y_reg <= e0y + e2y - (e1y <<< 1);
                d2x_reg <= e1x + e3x - (e2x <<< 1);
                d2y_reg <= e1y + e3y - (e2y <<< 1);
            end
            S_EVAL2:
            begin
                k_x_reg <= mid2(p_x_reg, q_x_reg);
                k_y_reg <= mid2(p_y_reg, q_y_reg);
                l_x_reg <= mid2(q_x_reg, r_x_reg);
                l_y_reg <= mid2(q_y_reg, r_y_reg);
                a1x_reg <= ABS_W'(d1x_reg < 0 ? -d1x_reg : d1x_reg);
                a1y_reg <= ABS_W'(d1y_reg < 0 ? -d1y_reg : d1y_reg);
                a2x_reg <= ABS_W'(d2x_reg < 0 ? -d2x_reg : d2x_reg);
                a2y_reg <= ABS_W'(d2y_reg < 0 ? -d2y_reg : d2y_reg);
            end
            S_EVAL3:
            begin
                m_x_reg <= mid2(k_x_reg, l_x_reg);
                m_y_reg <= mid2(k_y_reg, l_y_reg);
                s_reg   <= SUM_W'(a1x_reg) + SUM_W'(a1y_reg)
                         + SUM_W'(a2x_reg) + SUM_W'(a2y_reg);
            end
            S_DECIDE:
            begin
                if (!leaf)
                begin
                    // walk the left half next
                    cur_reg[2] <= p_x_reg;
                    cur_reg[3] <= p_y_reg;
                    cur_reg[4] <= k_x_reg;
                    cur_reg[5] <= k_y_reg;
                    cur_reg[6] <= m_x_reg;
                    cur_reg[7] <= m_y_reg;
                end
            end
            S_DIST1:
            begin
                adx_reg <= COORD_W'(dx < 0 ? -dx : dx);
                ady_reg <= COORD_W'(dy < 0 ? -dy : dy);
            end
            S_DIST2:
            begin
                sqx_reg <= adx_reg * adx_reg;
            end
            S_DIST3:
            begin
                sqy_reg <= ady_reg * ady_reg;
            end
            S_LOAD:
            begin
                cur_reg[0] <= pop_entry.x0;
                cur_reg[1] <= pop_entry.y0;
                cur_reg[2] <= pop_entry.x1;
                cur_reg[3] <= pop_entry.y1;
                cur_reg[4] <= pop_entry.x2;
                cur_reg[5] <= pop_entry.y2;
                cur_reg[6] <= pop_entry.x3;
                cur_reg[7] <= pop_entry.y3;
            end
            default:
            begin
            end
        endcase
    end

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_SLOTS))
        else $error("stack pointer beyond stack size");

    a_stack_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        seg.ready |-> sp_reg == '0)
        else $error("stack not empty between items");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> sp_reg != '0)
        else $error("pop from empty stack");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LEVEL_W'(MAX_DEPTH + 1))
        else $error("subdivision level beyond limit");

    a_push_then_walk: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> state_reg == S_EVAL1 && sp_reg == $past(sp_reg) + SP_W'(1))
        else $error("push did not advance the stack");

endmodule

FILE: tb/tb_bezier_curve_flattener_unit.sv
// testbench of the bezier flattener: random segments and min_step values against a predictor
module tb_bezier_curve_flattener_unit;
    import bcf_pkg::*;

    localparam int     LIMIT = 2_000_000;
    localparam longint MAXC  = 64'sd8388607;
    localparam longint MINC  = -64'sd8388608;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [STEP_W-1:0] cfg_wdata;

    bcf_seg_if seg_ch ();
    bcf_pt_if  pt_ch ();

    bezier_curve_flattener_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg       (seg_ch),
        .pts       (pt_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    bcf_in_t           seg_pending[$];
    bcf_out_t          expected_pts[$];
    logic [STEP_W-1:0] step_len = STEP_RESET;
    longint            last_x = 0;
    longint            last_y = 0;
    int                src_max = 14;
    int                sink_max = 14;
    int                src_wait;
    int                sink_wait;
    int                failures = 0;
    int                cycles = 0;

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic void queue_seg(bcf_in_t s);
        seg_pending = {seg_pending, s};
    endfunction

    function automatic void push_point(longint x, longint y, logic last);
        bcf_out_t pt;
        pt.point_x  = coord_t'(x);
        pt.point_y  = coord_t'(y);
        pt.run_last = last;
        expected_pts = {expected_pts, pt};
        last_x = x;
        last_y = y;
    endfunction

    // depth-first midpoint subdivision, left half first, right halves stacked
    function automatic void flatten_segment(bcf_in_t s);
        longint c[8];
        longint pend[STACK_SLOTS][8];
        int     pend_lvl[STACK_SLOTS];
        int     sp;
        int     lvl;
        longint p[2], q[2], r[2], k[2], l[2], m[2];
        longint bend;
        longint dx, dy;
        longint ms;
        bit     done;
        c[0] = $signed(s.start_x);
        c[1] = $signed(s.start_y);
        c[2] = $signed(s.ctrl1_x);
        c[3] = $signed(s.ctrl1_y);
        c[4] = $signed(s.ctrl2_x);
        c[5] = $signed(s.ctrl2_y);
        c[6] = $signed(s.end_x);
        c[7] = $signed(s.end_y);
        ms   = longint'(step_len);
        sp   = 0;
        lvl  = 0;
        done = 1'b0;
        if (s.path_start)
            push_point(c[0], c[1], 1'b0);
        while (!done)
        begin
            bend = 0;
            for (int a = 0; a < 2; a++)
            begin
                p[a] = (c[a] + c[2+a]) >>> 1;
                q[a] = (c[2+a] + c[4+a]) >>> 1;
                r[a] = (c[4+a] + c[6+a]) >>> 1;
                k[a] = (p[a] + q[a]) >>> 1;
                l[a] = (q[a] + r[a]) >>> 1;
                m[a] = (k[a] + l[a]) >>> 1;
                bend += magnitude(c[a] + c[4+a] - 2 * c[2+a]);
                bend += magnitude(c[2+a] + c[6+a] - 2 * c[4+a]);
            end
            if (4 * bend < ms || lvl > MAX_DEPTH)
            begin
                dx = m[0] - last_x;
                dy = m[1] - last_y;
                if (dx * dx + dy * dy > ms * ms)
                    push_point(m[0], m[1], 1'b0);
                if (sp == 0)
                    done = 1'b1;
                else
                begin
                    sp--;
                    c   = pend[sp];
                    lvl = pend_lvl[sp];
                end
            end
            else
            begin
                pend[sp]     = '{m[0], m[1], l[0], l[1], r[0], r[1], c[6], c[7]};
                pend_lvl[sp] = lvl + 1;
                sp++;
                c[2] = p[0];
                c[3] = p[1];
                c[4] = k[0];
                c[5] = k[1];
                c[6] = m[0];
                c[7] = m[1];
                lvl++;
            end
        end
        push_point(c[6] - c[6] + $signed(s.end_x), $signed(s.end_y), 1'b1);
    endfunction

    function automatic bcf_in_t mk_seg(longint x0, longint y0, longint x1, longint y1,
                                       longint x2, longint y2, longint x3, longint y3,
                                       logic ps);
        bcf_in_t s;
        s.start_x    = coord_t'(x0);
        s.start_y    = coord_t'(y0);
        s.ctrl1_x    = coord_t'(x1);
        s.ctrl1_y    = coord_t'(y1);
        s.ctrl2_x    = coord_t'(x2);
        s.ctrl2_y    = coord_t'(y2);
        s.end_x      = coord_t'(x3);
        s.end_y      = coord_t'(y3);
        s.path_start = ps;
        return s;
    endfunction

    // full-range noise, straight lines, and local curves of varied size
    function automatic bcf_in_t random_segment();
        longint v[8];
        longint span, bx, by, sx, sy;
        coord_t t;
        int     pick;
        pick = $urandom_range(0, 9);
        bx   = longint'($urandom_range(0, 1 << 23)) - (1 << 22);
        by   = longint'($urandom_range(0, 1 << 23)) - (1 << 22);
        if (pick < 2)
        begin
            for (int i = 0; i < 8; i++)
            begin
                t    = coord_t'($urandom());
                v[i] = t;
            end
        end
        else if (pick < 3)
        begin
            sx = longint'($urandom_range(0, 8192)) - 4096;
            sy = longint'($urandom_range(0, 8192)) - 4096;
            for (int i = 0; i < 4; i++)
            begin
                v[2*i]   = bx + i * sx;
                v[2*i+1] = by + i * sy;
            end
        end
        else
        begin
            span = longint'(1) << $urandom_range(2, 18);
            for (int i = 0; i < 4; i++)
            begin
                v[2*i]   = bx + longint'($urandom_range(0, 2 * span)) - span;
                v[2*i+1] = by + longint'($urandom_range(0, 2 * span)) - span;
            end
        end
        return mk_seg(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7],
                      logic'($urandom_range(0, 1)));
    endfunction

    // segment driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            seg_ch.valid <= 1'b0;
            src_wait = 0;
        end
        else
        begin
            if (seg_ch.valid && seg_ch.ready)
                flatten_segment(seg_ch.data);
            if (!seg_ch.valid || seg_ch.ready)
            begin
                if (src_wait > 0)
                begin
                    src_wait--;
                    seg_ch.valid <= 1'b0;
                end
                else if (seg_pending.size() != 0)
                begin
                    seg_ch.data  <= seg_pending.pop_front();
                    seg_ch.valid <= 1'b1;
                    src_wait = $urandom_range(0, src_max);
                end
                else
                    seg_ch.valid <= 1'b0;
            end
        end
    end

    // point monitor with random stalls
    always @(posedge clk)
    begin
        bcf_out_t got;
        bcf_out_t want;
        if (!rst_n)
        begin
            pt_ch.ready <= 1'b0;
            sink_wait = 0;
        end
        else
        begin
            if (pt_ch.valid && pt_ch.ready)
            begin
                got = pt_ch.data;
                if (expected_pts.size() == 0)
                begin
                    $error("unexpected point %0d,%0d", $signed(got.point_x),
                           $signed(got.point_y));
                    failures++;
                end
                else
                begin
                    want = expected_pts.pop_front();
                    if (got.point_x !== want.point_x)
                    begin
                        $error("point_x expected %0d got %0d", $signed(want.point_x),
                               $signed(got.point_x));
                        failures++;
                    end
                    if (got.point_y !== want.point_y)
                    begin
                        $error("point_y expected %0d got %0d", $signed(want.point_y),
                               $signed(got.point_y));
                        failures++;
                    end
                    if (got.run_last !== want.run_last)
                    begin
                        $error("run_last expected %0b got %0b", want.run_last, got.run_last);
                        failures++;
                    end
                end
                sink_wait = $urandom_range(0, sink_max);
            end
            else if (sink_wait > 0)
                sink_wait--;
            pt_ch.ready <= (sink_wait == 0);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic wait_idle();
        while (seg_pending.size() != 0 || seg_ch.valid || expected_pts.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_min_step(logic [STEP_W-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        step_len = v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_random(int n);
        src_max  = ($urandom_range(0, 3) == 0) ? 0 : 14;
        sink_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
        for (int i = 0; i < n; i++)
            queue_seg(random_segment());
        wait_idle();
    endtask

    initial
    begin
        seg_ch.valid = 1'b0;
        seg_ch.data  = '0;
        pt_ch.ready  = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        rst_n        = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset step of 1.0: degenerate points, extremes, lines and curves
        queue_seg(mk_seg(0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        queue_seg(mk_seg(0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        queue_seg(mk_seg(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, 1'b1));
        queue_seg(mk_seg(MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, 1'b0));
        queue_seg(mk_seg(MAXC, MINC, MINC, MAXC, MAXC, MINC, MINC, MAXC, 1'b1));
        queue_seg(mk_seg(MINC, MAXC, MAXC, MINC, MINC, MAXC, MAXC, MINC, 1'b0));
        queue_seg(mk_seg(0, 0, 256, 0, 512, 0, 768, 0, 1'b1));
        // no path start: distances run from the previous end point
        queue_seg(mk_seg(768, 0, 900, 300, 1100, 300, 1200, 0, 1'b0));
        queue_seg(mk_seg(0, 0, 0, 1024, 1024, 1024, 1024, 0, 1'b1));
        queue_seg(mk_seg(0, 0, 8192, 40000, -8192, 40000, 0, 0, 1'b0));
        queue_seg(mk_seg(-100, -100, -99, -98, -97, -95, -96, -90, 1'b1));
        queue_seg(mk_seg(MINC, MINC, MAXC, MINC, MINC, MAXC, MAXC, MAXC, 1'b1));
        wait_idle();

        // zero step: nothing flat, split to the deepest level
        write_min_step(16'd0);
        queue_seg(mk_seg(0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        queue_seg(mk_seg(0, 0, 256, 0, 512, 0, 768, 0, 1'b0));
        queue_seg(mk_seg(5, 5, 5, 5, 6, 6, 6, 6, 1'b1));
        run_random(30);

        write_min_step(16'hFFFF);
        queue_seg(mk_seg(MINC, MINC, MAXC, MINC, MINC, MAXC, MAXC, MAXC, 1'b1));
        queue_seg(mk_seg(0, 0, 0, 1024, 1024, 1024, 1024, 0, 1'b0));
        run_random(30);

        write_min_step(16'd1);
        run_random(30);

        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph % 2 == 0)
                write_min_step(16'($urandom_range(0, 65535)));
            else
                write_min_step(16'($urandom_range(1, 2048)));
            run_random(52);
        end

        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
design/bcf_pkg.sv
design/bcf_ifs.sv
design/bcf_ram.sv
design/bezier_curve_flattener_unit.sv
tb/tb_bezier_curve_flattener_unit.sv
